/* sv/ysa_pkg.sv */
`timescale 1ns / 1ps

package ysa_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int GAIN_BITS  = 12;
  localparam int GAIN_FRAC  = 8;
  localparam int COEF_FRAC  = 14;
  localparam int COEF_BITS  = 18;
  localparam int YUV_BITS   = 28;
  localparam int GPROD_BITS = YUV_BITS + GAIN_BITS + 1;
  localparam int CHROMA_BITS = 32;
  localparam int IPROD_BITS = COEF_BITS + CHROMA_BITS;
  localparam int ACC_BITS   = 48;
  localparam int RND_BITS   = ACC_BITS - 2 * COEF_FRAC;
  localparam int STAGES     = 4;

  typedef logic [PIXEL_BITS-1:0]         pixel_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [YUV_BITS-1:0]    yuv_t;
  typedef logic signed [GPROD_BITS-1:0]  gprod_t;
  typedef logic signed [CHROMA_BITS-1:0] chroma_t;
  typedef logic signed [IPROD_BITS-1:0]  iprod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  localparam coef_t K_Y_R = 18'sd4899;
  localparam coef_t K_Y_G = 18'sd9617;
  localparam coef_t K_Y_B = 18'sd1868;
  localparam coef_t K_U_R = -18'sd2408;
  localparam coef_t K_U_G = -18'sd4735;
  localparam coef_t K_U_B = 18'sd7143;
  localparam coef_t K_V_R = 18'sd10076;
  localparam coef_t K_V_G = -18'sd8438;
  localparam coef_t K_V_B = -18'sd1638;
  localparam coef_t K_R_V = 18'sd18678;
  localparam coef_t K_G_U = -18'sd6472;
  localparam coef_t K_G_V = -18'sd9519;
  localparam coef_t K_B_U = 18'sd33292;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 12'd256;

  function automatic logic signed [COEF_BITS+PIXEL_BITS:0] mul_px(coef_t k, pixel_t p);
    logic signed [PIXEL_BITS:0] ps;
    ps = $signed({1'b0, p});
    return k * ps;
  endfunction

  function automatic yuv_t dot3(coef_t ka, coef_t kb, coef_t kc,
                               pixel_t pa, pixel_t pb, pixel_t pc);
    logic signed [COEF_BITS+PIXEL_BITS+2:0] s;
    s = (COEF_BITS+PIXEL_BITS+3)'(mul_px(ka, pa))
      + (COEF_BITS+PIXEL_BITS+3)'(mul_px(kb, pb))
      + (COEF_BITS+PIXEL_BITS+3)'(mul_px(kc, pc));
    return s[YUV_BITS-1:0];
  endfunction

  function automatic chroma_t round_gain(gprod_t x);
    gprod_t r;
    r = (x + GPROD_BITS'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    return r[CHROMA_BITS-1:0];
  endfunction

  function automatic pixel_t round_clamp(acc_t x);
    acc_t r;
    logic signed [RND_BITS-1:0] v;
    r = (x + ACC_BITS'(64'd1 << (2 * COEF_FRAC - 1))) >>> (2 * COEF_FRAC);
    v = r[RND_BITS-1:0];
    if (v < 0) begin
      return '0;
    end else if (v > RND_BITS'({PIXEL_BITS{1'b1}})) begin
      return '1;
    end else begin
      return v[PIXEL_BITS-1:0];
    end
  endfunction

endpackage

/* sv/yuv_saturation_adjust.sv */
`timescale 1ns / 1ps

// Channel  Direction  Fields (low bit up)
// in_      input      tdata: red_in[11:0], green_in[23:12], blue_in[35:24], zero[39:36]
// out_     output     tdata: red_out[11:0], green_out[23:12], blue_out[35:24], zero[39:36]
// cfg_     input      wr_data: saturation_gain[11:0]
//
// Four register stages: luma/chroma sums, gain multiply, inverse multiply, sum/round/clamp.
// One transaction per cycle while out_tready is high; out_tvalid marks the last stage full.
// Stage ready ripples back from out_tready so empty stages fill while the output stalls.
// rst_n is synchronous, active low; it empties the pipeline and sets the gain to 1.0.

module yuv_saturation_adjust
  import ysa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // red_in, green_in, blue_in, pad
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // red_out, green_out, blue_out, pad
  input  logic                 cfg_wr_en,
  input  logic [GAIN_BITS-1:0] cfg_wr_data
);

  logic [GAIN_BITS-1:0] gain_r;
  logic [STAGES-1:0]    vld_r, vld_nxt;
  logic [STAGES-1:0]    adv;

  yuv_t    y1_r, u1_r, v1_r;
  yuv_t    y2_r;
  gprod_t  ug2_r, vg2_r;
  yuv_t    y3_r;
  iprod_t  rv3_r, gu3_r, gv3_r, bu3_r;
  pixel_t  red4_r, green4_r, blue4_r;

  pixel_t  red_px, green_px, blue_px;
  chroma_t u_s, v_s;
  acc_t    y_ext, acc_r, acc_g, acc_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = adv[0];

  assign red_px   = in_tdata[11:0];
  assign green_px = in_tdata[23:12];
  assign blue_px  = in_tdata[35:24];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      y1_r <= dot3(K_Y_R, K_Y_G, K_Y_B, red_px, green_px, blue_px);
      u1_r <= dot3(K_U_R, K_U_G, K_U_B, red_px, green_px, blue_px);
      v1_r <= dot3(K_V_R, K_V_G, K_V_B, red_px, green_px, blue_px);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      y2_r  <= y1_r;
      ug2_r <= u1_r * $signed({1'b0, gain_r});
      vg2_r <= v1_r * $signed({1'b0, gain_r});
    end
  end

  assign u_s = round_gain(ug2_r);
  assign v_s = round_gain(vg2_r);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      y3_r  <= y2_r;
      rv3_r <= K_R_V * v_s;
      gu3_r <= K_G_U * u_s;
      gv3_r <= K_G_V * v_s;
      bu3_r <= K_B_U * u_s;
    end
  end

  always_comb begin
    y_ext = ACC_BITS'(y3_r) <<< COEF_FRAC;
    acc_r = y_ext + rv3_r[ACC_BITS-1:0];
    acc_g = y_ext + gu3_r[ACC_BITS-1:0] + gv3_r[ACC_BITS-1:0];
    acc_b = y_ext + bu3_r[ACC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      red4_r   <= round_clamp(acc_r);
      green4_r <= round_clamp(acc_g);
      blue4_r  <= round_clamp(acc_b);
    end
  end

  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = {4'b0000, blue4_r, green4_r, red4_r};

`ifndef SYNTHESIS
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with room in the pipeline");

  a_occupancy_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !(out_tvalid && out_tready))
      |=> $countones(vld_r) == $past($countones(vld_r)) + 1)
    else $error("accepted transaction lost in the pipeline");

  a_occupancy_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_tvalid && in_tready) && out_tvalid && out_tready)
      |=> $countones(vld_r) + 1 == $past($countones(vld_r)))
    else $error("delivered transaction repeated in the pipeline");
`endif

endmodule
